// ----- design/smask_pkg.sv -----
// ----------------------------------------------------------------------------
// smask_pkg
// Shared types and constants for the stream pattern masker.
// ----------------------------------------------------------------------------
`default_nettype none

package smask_pkg;

    // Pattern storage is fixed by the register map: two 64-bit words.
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [7:0] STAR_BYTE = 8'd42;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    // Pattern and clamped length as seen by the resolver
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [LEN_W-1:0]          length;
    } smask_cfg_t;

endpackage

`default_nettype wire

// ----- design/smask_cfg.sv -----
// ----------------------------------------------------------------------------
// smask_cfg
// Configuration registers: pattern bytes and pattern length, with the
// length clamped to the supported range.
// ----------------------------------------------------------------------------
`default_nettype none

module smask_cfg #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [smask_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smask_pkg::CFG_W-1:0]         cfg_data,
    output smask_pkg::smask_cfg_t                    cfg_out
);
    import smask_pkg::*;

    logic [CFG_W-1:0] pat_low_reg;
    logic [CFG_W-1:0] pat_high_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_eff;

    // Accept a write request in every cycle
    assign cfg_ready = 1'b1;

    // Write the addressed register; ignore unmapped indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= LEN_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                REG_PAT_HIGH: pat_high_reg <= cfg_data;
                REG_PAT_LEN:  len_reg      <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp length: zero acts as one, oversize acts as the window depth
    always_comb begin
        if (len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_PATTERN_LEN)) begin
            len_eff = LEN_W'(MAX_PATTERN_LEN);
        end else begin
            len_eff = len_reg;
        end
    end

    assign cfg_out.pattern = {pat_high_reg, pat_low_reg};
    assign cfg_out.length  = len_eff;

endmodule

`default_nettype wire

// ----- design/smask_core.sv -----
// ----------------------------------------------------------------------------
// smask_core
// Window resolver and output register. Unless stalled, each cycle it resolves
// at most one output byte: a pending star, a pattern compare or a flush byte.
// ----------------------------------------------------------------------------
`default_nettype none

module smask_core #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire smask_pkg::smask_cfg_t cfg_in,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    output logic                       in_take,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_out_masked,
    output logic                       m_out_last
);
    import smask_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int IDX_W  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [MAX_PATTERN_LEN-1:0][7:0] window_reg, window_next;
    logic [FILL_W-1:0]               fill_reg, fill_next;
    logic [FILL_W-1:0]               star_reg, star_next;
    logic                            flush_reg, flush_next;
    logic                            busy_reg, busy_next;
    logic                            out_valid_reg;
    logic [7:0]                      out_byte_reg;
    logic                            out_masked_reg;
    logic                            out_last_reg;

    logic                            step_en;
    logic                            pending;
    logic                            active;
    logic [MAX_PATTERN_LEN-1:0][7:0] w;
    logic [FILL_W-1:0]               wfill;
    logic                            wflush;
    logic                            hit;
    logic                            emit;
    logic [7:0]                      emit_byte;
    logic                            emit_masked;
    logic                            emit_last;
    logic [LEN_W-1:0]                drop;
    logic [LEN_W-1:0]                len;

    assign len = cfg_in.length;

    // Advance only when the output register is free or being drained
    assign step_en = !out_valid_reg || m_ready;
    assign pending = (star_reg != '0) || flush_reg ||
                     (busy_reg && (LEN_W'(fill_reg) >= len));
    assign in_take = in_valid && !pending && step_en;
    assign active  = in_take || busy_reg;

    // Append the incoming byte to the working window
    always_comb begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (in_take && (fill_reg[IDX_W-1:0] == IDX_W'(i))) begin
                w[i] = in_byte;
            end else begin
                w[i] = window_reg[i];
            end
        end
        wfill  = in_take ? fill_reg + FILL_W'(1) : fill_reg;
        wflush = in_take ? in_last : flush_reg;
    end

    // Compare the oldest len bytes with the pattern
    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if ((LEN_W'(i) < len) && (w[i] != cfg_in.pattern[i])) begin
                hit = 1'b0;
            end
        end
    end

    // Pick one output byte: pending star, compare result, or flush byte
    always_comb begin
        emit        = 1'b0;
        emit_byte   = w[0];
        emit_masked = 1'b0;
        drop        = '0;
        star_next   = star_reg;
        if (star_reg != '0) begin
            emit        = 1'b1;
            emit_byte   = STAR_BYTE;
            emit_masked = 1'b1;
            star_next   = star_reg - FILL_W'(1);
        end else if (active && (LEN_W'(wfill) >= len)) begin
            emit = 1'b1;
            if (hit) begin
                emit_byte   = STAR_BYTE;
                emit_masked = 1'b1;
                star_next   = FILL_W'(len - LEN_W'(1));
                drop        = len;
            end else begin
                drop = LEN_W'(1);
            end
        end else if (wflush && (wfill != '0)) begin
            emit = 1'b1;
            drop = LEN_W'(1);
        end
        fill_next  = wfill - FILL_W'(drop);
        emit_last  = emit && wflush && (star_next == '0) && (fill_next == '0);
        flush_next = wflush && emit && !emit_last;
        busy_next  = active && (LEN_W'(fill_next) >= len);
    end

    // Drop resolved bytes from the front of the window
    always_comb begin
        logic [LEN_W:0] src;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            src = (LEN_W+1)'(i) + {1'b0, drop};
            if (src < (LEN_W+1)'(MAX_PATTERN_LEN)) begin
                window_next[i] = w[src[IDX_W-1:0]];
            end else begin
                window_next[i] = w[i];
            end
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            star_reg      <= '0;
            flush_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            fill_reg      <= fill_next;
            star_reg      <= star_next;
            flush_reg     <= flush_next;
            busy_reg      <= busy_next;
            out_valid_reg <= emit;
        end
    end

    // Hold window and output payload
    always_ff @(posedge aclk) begin
        if (step_en) begin
            window_reg     <= window_next;
            out_byte_reg   <= emit_byte;
            out_masked_reg <= emit_masked;
            out_last_reg   <= emit_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_out_masked = out_masked_reg;
    assign m_out_last   = out_last_reg;

    // Window never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_PATTERN_LEN))
        else $error("window fill beyond depth");

    // Pending stars always follow a star already in the output register
    a_star_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (star_reg != '0) |-> (out_valid_reg && out_masked_reg))
        else $error("stars pending without a star in flight");

    // Masked bytes are always stars
    a_star_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_masked_reg) |-> (out_byte_reg == STAR_BYTE))
        else $error("masked byte is not a star");

    // No new byte enters while a match or flush is still draining
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> ((star_reg == '0) && !flush_reg))
        else $error("byte taken while resolving");

endmodule

`default_nettype wire

// ----- design/stream_pattern_masker.sv -----
// ----------------------------------------------------------------------------
// stream_pattern_masker
// Masks every non-overlapping occurrence of a configured byte pattern with
// stars and passes all other bytes through in order.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and gives one byte per cycle unless the
// output stalls or a match or flush is draining; the single output register
// sets the pace. A byte that resolves at most one output byte leaves the input
// free in the next cycle unless the output stalls. A match of N bytes gives N
// stars while input pauses; the byte marked last flushes the K bytes still
// held. An accepted byte passes the input register and the output register.
// Configuration writes are taken every cycle and must only be issued while no
// stream byte is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_masker #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [smask_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smask_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_in_byte,
    input  wire logic                             s_in_last,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_out_byte,
    output logic                                  m_out_masked,
    output logic                                  m_out_last
);
    import smask_pkg::*;

    smask_cfg_t  cfg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_take;

    smask_cfg #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    // Hold one input request until the resolver takes it
    assign s_ready = !in_valid_reg || in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (in_take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_in_last;
        end
    end

    smask_core #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_in       (cfg),
        .in_valid     (in_valid_reg),
        .in_byte      (in_byte_reg),
        .in_last      (in_last_reg),
        .in_take      (in_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_masked (m_out_masked),
        .m_out_last   (m_out_last)
    );

endmodule

`default_nettype wire
